// ===== rtl/awf_pkg.sv =====
// ----------------------------------------------------------------------------
// awf_pkg
// Shared types and constants for the ARINC 429 word filter with batch
// acknowledge: status codes, register map, reset values, acknowledge word.
// ----------------------------------------------------------------------------
`default_nettype none

package awf_pkg;

    // Result status codes
    localparam logic [2:0] ST_NONE       = 3'd0;
    localparam logic [2:0] ST_ACCEPTED   = 3'd1;
    localparam logic [2:0] ST_FILTERED   = 3'd2;
    localparam logic [2:0] ST_PARITY     = 3'd3;
    localparam logic [2:0] ST_OVERFLOW   = 3'd4;
    localparam logic [2:0] ST_ZERO       = 3'd5;
    localparam logic [2:0] ST_ACK        = 3'd6;
    localparam logic [2:0] ST_INCOMPLETE = 3'd7;

    // Input op codes
    localparam logic OP_WORD = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // Register map, index = paddr[4:2]
    localparam logic [2:0] REG_STREAM_MODE   = 3'd0;
    localparam logic [2:0] REG_FILTER_ENABLE = 3'd1;
    localparam logic [2:0] REG_FILTER_0      = 3'd2;
    localparam logic [2:0] REG_FILTER_1      = 3'd3;
    localparam logic [2:0] REG_FILTER_2      = 3'd4;
    localparam logic [2:0] REG_EXPECTED      = 3'd5;
    localparam logic [2:0] REG_IDLE_FLUSH    = 3'd6;

    // Register reset values
    localparam logic [9:0]  RST_FILTER_0   = 10'h0A5;
    localparam logic [9:0]  RST_FILTER_1   = 10'h1B1;
    localparam logic [9:0]  RST_FILTER_2   = 10'h2C2;
    localparam logic [10:0] RST_EXPECTED   = 11'd1000;
    localparam logic [15:0] RST_IDLE_FLUSH = 16'd8000;

    // Acknowledge word fields
    localparam logic [7:0] ACK_LBL = 8'hAC;
    localparam logic [1:0] ACK_SDI = 2'd3;
    localparam logic [1:0] ACK_SSM = 2'd3;

    localparam logic [10:0] PERR_MAX = 11'h7FF;
    localparam logic [15:0] IDLE_MAX = 16'hFFFF;

    typedef struct packed {
        logic        stream_mode;
        logic        filter_enable;
        logic [9:0]  filter_entry_0;
        logic [9:0]  filter_entry_1;
        logic [9:0]  filter_entry_2;
        logic [10:0] expected_words;
        logic [15:0] idle_flush_ticks;
    } cfg_t;

    typedef struct packed {
        logic zero;
        logic parity_bad;
        logic listed;
    } cls_t;

    // Acknowledge word with odd parity in bit 31
    function automatic logic [31:0] make_ack(input logic [18:0] num);
        logic [30:0] body;
        body = {ACK_SSM, num, ACK_SDI, ACK_LBL};
        return {~(^body), body};
    endfunction

endpackage

`default_nettype wire

// ===== rtl/arinc429_word_filter_batch_ack.sv =====
// ----------------------------------------------------------------------------
// arinc429_word_filter_batch_ack
// ARINC 429 receive word filter with label/SDI whitelist, running totals
// and batch acknowledge.
//
// Input channel (in_valid / in_stall): op = 0 carries a received word in
// rx_word, op = 1 marks one microsecond tick. Every input transaction gives
// exactly one output transaction (out_valid / out_stall) with status, word
// fields, acknowledge word, batch number, batch fill and running totals.
// Configuration registers sit on the APB port at 4*index; write only while
// no transaction is in flight. pready is tied high.
// A taken item waits in the input register; the state update between the
// two registers then loads the result register, which presents it. The block
// takes one transaction per cycle while the result register is free to load.
// A stalled result holds; the input register still takes one more item and
// in_stall rises only when both registers are full and out_stall is high.
// Reset clears all totals and batch state and loads register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module arinc429_word_filter_batch_ack
    import awf_pkg::*;
#(
    parameter int unsigned BATCH_CAPACITY = 1024
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        op,
    input  wire logic [31:0] rx_word,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [2:0]       status,
    output logic [7:0]       label,
    output logic [1:0]       sdi,
    output logic [18:0]      data,
    output logic [1:0]       ssm,
    output logic [31:0]      ack_tx,
    output logic [31:0]      batch_seq,
    output logic [10:0]      batch_words,
    output logic [31:0]      accepted_count,
    output logic [31:0]      filtered_count,
    output logic [31:0]      parity_error_count,
    output logic [31:0]      overflow_count
);

    cfg_t        cfg_reg;
    logic        cfg_write;
    logic [2:0]  reg_index;

    logic        stage_valid_reg;
    logic        stage_op_reg;
    logic [31:0] stage_word_reg;
    logic        out_valid_reg;
    logic        out_free;
    logic        advance;
    logic        in_take;
    cls_t        cls;

    // ------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign reg_index = paddr[4:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.stream_mode      <= 1'b0;
            cfg_reg.filter_enable    <= 1'b1;
            cfg_reg.filter_entry_0   <= RST_FILTER_0;
            cfg_reg.filter_entry_1   <= RST_FILTER_1;
            cfg_reg.filter_entry_2   <= RST_FILTER_2;
            cfg_reg.expected_words   <= RST_EXPECTED;
            cfg_reg.idle_flush_ticks <= RST_IDLE_FLUSH;
        end
        else if (cfg_write)
        begin
            case (reg_index)
                REG_STREAM_MODE:   cfg_reg.stream_mode      <= pwdata[0];
                REG_FILTER_ENABLE: cfg_reg.filter_enable    <= pwdata[0];
                REG_FILTER_0:      cfg_reg.filter_entry_0   <= pwdata[9:0];
                REG_FILTER_1:      cfg_reg.filter_entry_1   <= pwdata[9:0];
                REG_FILTER_2:      cfg_reg.filter_entry_2   <= pwdata[9:0];
                REG_EXPECTED:      cfg_reg.expected_words   <= pwdata[10:0];
                REG_IDLE_FLUSH:    cfg_reg.idle_flush_ticks <= pwdata[15:0];
                default:           cfg_reg                  <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_index)
            REG_STREAM_MODE:   prdata = {31'd0, cfg_reg.stream_mode};
            REG_FILTER_ENABLE: prdata = {31'd0, cfg_reg.filter_enable};
            REG_FILTER_0:      prdata = {22'd0, cfg_reg.filter_entry_0};
            REG_FILTER_1:      prdata = {22'd0, cfg_reg.filter_entry_1};
            REG_FILTER_2:      prdata = {22'd0, cfg_reg.filter_entry_2};
            REG_EXPECTED:      prdata = {21'd0, cfg_reg.expected_words};
            REG_IDLE_FLUSH:    prdata = {16'd0, cfg_reg.idle_flush_ticks};
            default:           prdata = 32'd0;
        endcase
    end

    // ------------------------------------------------------------------
    // Input register and handshake
    // ------------------------------------------------------------------
    assign out_free = !out_valid_reg || !out_stall;
    assign advance  = stage_valid_reg && out_free;
    assign in_stall = stage_valid_reg && !out_free;
    assign in_take  = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (in_take)
                stage_valid_reg <= 1'b1;
            else if (advance)
                stage_valid_reg <= 1'b0;

            if (advance)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            stage_op_reg   <= op;
            stage_word_reg <= rx_word;
        end
    end

    assign out_valid = out_valid_reg;

    // ------------------------------------------------------------------
    // Classification and batch state
    // ------------------------------------------------------------------
    awf_classify u_classify
    (
        .word (stage_word_reg),
        .cfg  (cfg_reg),
        .cls  (cls)
    );

    awf_batch #(
        .BATCH_CAPACITY (BATCH_CAPACITY)
    ) u_batch
    (
        .clk                (clk),
        .rst_n              (rst_n),
        .advance            (advance),
        .op                 (stage_op_reg),
        .word               (stage_word_reg),
        .cls                (cls),
        .cfg                (cfg_reg),
        .status             (status),
        .label              (label),
        .sdi                (sdi),
        .data               (data),
        .ssm                (ssm),
        .ack_tx             (ack_tx),
        .batch_seq          (batch_seq),
        .batch_words        (batch_words),
        .accepted_count     (accepted_count),
        .filtered_count     (filtered_count),
        .parity_error_count (parity_error_count),
        .overflow_count     (overflow_count)
    );

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // input side only backs up when both registers hold a transaction
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (stage_valid_reg && out_valid && out_stall))
        else $error("in_stall raised with a free register");

    // an acknowledge result carries a well-formed odd-parity word
    a_ack_form: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == ST_ACK) |->
            (ack_tx[7:0] == ACK_LBL && ack_tx[9:8] == ACK_SDI &&
             ack_tx[30:29] == ACK_SSM && (^ack_tx) == 1'b1 &&
             label == ACK_LBL && data == batch_seq[18:0]))
        else $error("malformed acknowledge word");

    // acknowledge word is zero for every other status
    a_ack_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != ST_ACK) |-> (ack_tx == 32'd0))
        else $error("acknowledge word set without acknowledge status");

endmodule

`default_nettype wire

// ===== rtl/awf_classify.sv =====
// ----------------------------------------------------------------------------
// awf_classify
// Zero detect, odd parity check and label/SDI whitelist match of one word.
// ----------------------------------------------------------------------------
`default_nettype none

module awf_classify
    import awf_pkg::*;
(
    input  wire logic [31:0] word,
    input  wire cfg_t        cfg,
    output cls_t             cls
);

    logic [9:0] key;

    assign key = word[9:0];

    always_comb
    begin
        cls.zero       = (word == 32'd0);
        cls.parity_bad = ~(^word);
        cls.listed     = ~cfg.filter_enable
                       || (key == cfg.filter_entry_0)
                       || (key == cfg.filter_entry_1)
                       || (key == cfg.filter_entry_2);
    end

endmodule

`default_nettype wire

// ===== rtl/awf_batch.sv =====
// ----------------------------------------------------------------------------
// awf_batch
// Batch state, running totals and result register. On each advance the
// item in the input register updates the state and loads the result.
// ----------------------------------------------------------------------------
`default_nettype none

module awf_batch
    import awf_pkg::*;
#(
    parameter int unsigned BATCH_CAPACITY = 1024
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        advance,
    input  wire logic        op,
    input  wire logic [31:0] word,
    input  wire cls_t        cls,
    input  wire cfg_t        cfg,
    output logic [2:0]       status,
    output logic [7:0]       label,
    output logic [1:0]       sdi,
    output logic [18:0]      data,
    output logic [1:0]       ssm,
    output logic [31:0]      ack_tx,
    output logic [31:0]      batch_seq,
    output logic [10:0]      batch_words,
    output logic [31:0]      accepted_count,
    output logic [31:0]      filtered_count,
    output logic [31:0]      parity_error_count,
    output logic [31:0]      overflow_count
);

    localparam int unsigned FW = $clog2(BATCH_CAPACITY + 1);
    localparam int unsigned CW = (FW > 11) ? FW : 11;

    logic [FW-1:0] fill_reg, fill_next;
    logic [10:0]   perr_reg, perr_next;
    logic [15:0]   idle_reg, idle_next;
    logic          capture_reg, capture_next;
    logic [31:0]   batches_reg, batches_next;
    logic [31:0]   acc_reg, acc_next;
    logic [31:0]   filt_reg, filt_next;
    logic [31:0]   par_reg, par_next;
    logic [31:0]   ovf_reg, ovf_next;

    logic [2:0]    status_reg, status_next;
    logic [31:0]   fw_reg, fw_next;
    logic [31:0]   ack_reg, ack_next;
    logic [10:0]   bw_reg, bw_next;

    logic [15:0]   idle_inc;
    logic [2:0]    cls_status;
    logic          do_class;
    logic          closed;
    logic [FW-1:0] bw_fill;
    logic [CW-1:0] bw_ext;

    always_comb
    begin
        if (cls.parity_bad)
            cls_status = ST_PARITY;
        else if (!cls.listed)
            cls_status = ST_FILTERED;
        else
            cls_status = ST_ACCEPTED;
    end

    assign idle_inc = (idle_reg == IDLE_MAX) ? idle_reg : idle_reg + 16'd1;

    always_comb
    begin
        fill_next    = fill_reg;
        perr_next    = perr_reg;
        idle_next    = idle_reg;
        capture_next = capture_reg;
        batches_next = batches_reg;
        acc_next     = acc_reg;
        filt_next    = filt_reg;
        par_next     = par_reg;
        ovf_next     = ovf_reg;
        status_next  = ST_NONE;
        fw_next      = 32'd0;
        ack_next     = 32'd0;
        do_class     = 1'b0;
        closed       = 1'b0;

        if (op == OP_WORD)
        begin
            fw_next = word;
            if (cls.zero)
            begin
                status_next = ST_ZERO;
            end
            else if (cfg.stream_mode)
            begin
                do_class = 1'b1;
            end
            else
            begin
                capture_next = 1'b1;
                idle_next    = 16'd0;
                if (fill_reg < FW'(BATCH_CAPACITY))
                begin
                    fill_next = fill_reg + FW'(1);
                    do_class  = 1'b1;
                    if (cls.parity_bad && perr_reg != PERR_MAX)
                        perr_next = perr_reg + 11'd1;
                end
                else
                begin
                    ovf_next    = ovf_reg + 32'd1;
                    status_next = ST_OVERFLOW;
                end
            end
        end
        else if (!cfg.stream_mode && capture_reg && fill_reg != '0)
        begin
            idle_next = idle_inc;
            if (idle_inc >= cfg.idle_flush_ticks)
            begin
                closed       = 1'b1;
                batches_next = batches_reg + 32'd1;
                if (CW'(fill_reg) >= CW'(cfg.expected_words) && perr_reg == 11'd0)
                begin
                    ack_next    = make_ack(batches_next[18:0]);
                    fw_next     = ack_next;
                    status_next = ST_ACK;
                end
                else
                begin
                    status_next = ST_INCOMPLETE;
                end
            end
        end

        if (do_class)
        begin
            status_next = cls_status;
            case (cls_status)
                ST_PARITY:   par_next  = par_reg + 32'd1;
                ST_FILTERED: filt_next = filt_reg + 32'd1;
                ST_ACCEPTED: acc_next  = acc_reg + 32'd1;
                default:     acc_next  = acc_reg;
            endcase
        end

        // report the fill at close, then empty the batch
        bw_fill = closed ? fill_reg : fill_next;
        if (closed)
        begin
            fill_next    = '0;
            perr_next    = 11'd0;
            idle_next    = 16'd0;
            capture_next = 1'b0;
        end
    end

    assign bw_ext  = CW'(bw_fill);
    assign bw_next = bw_ext[10:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg    <= '0;
            perr_reg    <= 11'd0;
            idle_reg    <= 16'd0;
            capture_reg <= 1'b0;
            batches_reg <= 32'd0;
            acc_reg     <= 32'd0;
            filt_reg    <= 32'd0;
            par_reg     <= 32'd0;
            ovf_reg     <= 32'd0;
        end
        else if (advance)
        begin
            fill_reg    <= fill_next;
            perr_reg    <= perr_next;
            idle_reg    <= idle_next;
            capture_reg <= capture_next;
            batches_reg <= batches_next;
            acc_reg     <= acc_next;
            filt_reg    <= filt_next;
            par_reg     <= par_next;
            ovf_reg     <= ovf_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            status_reg <= status_next;
            fw_reg     <= fw_next;
            ack_reg    <= ack_next;
            bw_reg     <= bw_next;
        end
    end

    // Totals only move on advance, so they always match the held result
    assign status             = status_reg;
    assign label              = fw_reg[7:0];
    assign sdi                = fw_reg[9:8];
    assign data               = fw_reg[28:10];
    assign ssm                = fw_reg[30:29];
    assign ack_tx             = ack_reg;
    assign batch_seq          = batches_reg;
    assign batch_words        = bw_reg;
    assign accepted_count     = acc_reg;
    assign filtered_count     = filt_reg;
    assign parity_error_count = par_reg;
    assign overflow_count     = ovf_reg;

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the ARINC 429 word filter with batch acknowledge.
// A queue-fed driver offers words and ticks with random gaps, a monitor
// scores every result against an in-bench predictor of the filter, batch
// and counter behavior, and the receiver stalls at random, once for a long
// stretch. Register settings change between phases while the block is idle.
// ----------------------------------------------------------------------------

module tb
    import awf_pkg::*;
();

    localparam int BATCH_CAP = 1024;

    typedef struct {
        logic        op;
        logic [31:0] word;
        int          gap;
    } word_item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  label;
        logic [1:0]  sdi;
        logic [18:0] data;
        logic [1:0]  ssm;
        logic [31:0] ack_tx;
        logic [31:0] batch_seq;
        logic [10:0] batch_words;
        logic [31:0] accepted_count;
        logic [31:0] filtered_count;
        logic [31:0] parity_error_count;
        logic [31:0] overflow_count;
    } filter_report_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        op = 1'b0;
    logic [31:0] rx_word = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [2:0]  status;
    logic [7:0]  label;
    logic [1:0]  sdi;
    logic [18:0] data;
    logic [1:0]  ssm;
    logic [31:0] ack_tx;
    logic [31:0] batch_seq;
    logic [10:0] batch_words;
    logic [31:0] accepted_count;
    logic [31:0] filtered_count;
    logic [31:0] parity_error_count;
    logic [31:0] overflow_count;

    arinc429_word_filter_batch_ack dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready),
        .in_valid           (in_valid),
        .in_stall           (in_stall),
        .op                 (op),
        .rx_word            (rx_word),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .status             (status),
        .label              (label),
        .sdi                (sdi),
        .data               (data),
        .ssm                (ssm),
        .ack_tx             (ack_tx),
        .batch_seq          (batch_seq),
        .batch_words        (batch_words),
        .accepted_count     (accepted_count),
        .filtered_count     (filtered_count),
        .parity_error_count (parity_error_count),
        .overflow_count     (overflow_count)
    );

    always #10 clk = ~clk;

    // Register shadow and predicted filter state
    cfg_t        cfg_now;
    logic [10:0] bat_fill;
    logic [10:0] bat_perr;
    logic [15:0] idle_run;
    logic        capture_open;
    logic [31:0] closed_total;
    logic [31:0] acc_total;
    logic [31:0] filt_total;
    logic [31:0] par_total;
    logic [31:0] ovf_total;

    word_item_t     pending_words[$];
    filter_report_t awaited_reports[$];

    word_item_t cur_word;
    bit         have_cur = 1'b0;
    int         gap_left = 0;
    bit         in_taken = 1'b0;
    bit         out_taken = 1'b0;
    int         stall_left = 0;
    int         recv_burst = 0;
    int         hold_left = 0;
    bit         hold_off_req = 1'b0;
    bit         hold_served = 1'b0;
    int         send_burst = 0;
    bit         quick = 1'b0;
    int         mismatches = 0;
    int         random_sent = 0;

    // Parity and whitelist grading of one nonzero word; updates the totals
    function automatic logic [2:0] grade_word(input logic [31:0] w);
        logic [9:0] key;
        key = w[9:0];
        if (^w == 1'b0)
        begin
            par_total++;
            return ST_PARITY;
        end
        if (cfg_now.filter_enable && key != cfg_now.filter_entry_0
            && key != cfg_now.filter_entry_1 && key != cfg_now.filter_entry_2)
        begin
            filt_total++;
            return ST_FILTERED;
        end
        acc_total++;
        return ST_ACCEPTED;
    endfunction

    function automatic filter_report_t filter_step(input logic in_op, input logic [31:0] w);
        filter_report_t r;
        logic [31:0]    fw;
        logic           closed;
        r = '0;
        fw = '0;
        closed = 1'b0;
        if (in_op == OP_WORD)
        begin
            fw = w;
            if (w == 32'd0)
                r.status = ST_ZERO;
            else if (cfg_now.stream_mode)
                r.status = grade_word(w);
            else
            begin
                capture_open = 1'b1;
                idle_run = '0;
                if (bat_fill < 11'(BATCH_CAP))
                begin
                    bat_fill++;
                    r.status = grade_word(w);
                    if (r.status == ST_PARITY && bat_perr != PERR_MAX)
                        bat_perr++;
                end
                else
                begin
                    ovf_total++;
                    r.status = ST_OVERFLOW;
                end
            end
        end
        else if (!cfg_now.stream_mode && capture_open && bat_fill != '0)
        begin
            if (idle_run != IDLE_MAX)
                idle_run++;
            if (idle_run >= cfg_now.idle_flush_ticks)
            begin
                closed = 1'b1;
                closed_total++;
                if (bat_fill >= cfg_now.expected_words && bat_perr == '0)
                begin
                    fw = {1'b0, ACK_SSM, closed_total[18:0], ACK_SDI, ACK_LBL};
                    fw[31] = ~(^fw[30:0]);
                    r.ack_tx = fw;
                    r.status = ST_ACK;
                end
                else
                    r.status = ST_INCOMPLETE;
            end
        end
        r.label = fw[7:0];
        r.sdi = fw[9:8];
        r.data = fw[28:10];
        r.ssm = fw[30:29];
        r.batch_seq = closed_total;
        r.batch_words = bat_fill;
        r.accepted_count = acc_total;
        r.filtered_count = filt_total;
        r.parity_error_count = par_total;
        r.overflow_count = ovf_total;
        if (closed)
        begin
            bat_fill = '0;
            bat_perr = '0;
            idle_run = '0;
            capture_open = 1'b0;
        end
        return r;
    endfunction

    function automatic logic [31:0] arinc_word(input logic [9:0] key, input logic [18:0] dat,
                                               input logic [1:0] sm, input logic good);
        logic [30:0] body;
        body = {sm, dat, key};
        return {good ? ~(^body) : ^body, body};
    endfunction

    function automatic logic [9:0] listed_key();
        case ($urandom_range(0, 2))
            0: return cfg_now.filter_entry_0;
            1: return cfg_now.filter_entry_1;
            default: return cfg_now.filter_entry_2;
        endcase
    endfunction

    // Mostly whitelisted words with good parity, plus zeros, raw and bad-parity words
    function automatic logic [31:0] pick_word();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 5)
            return 32'd0;
        if (sel < 15)
            return $urandom;
        if (sel < 80)
            return arinc_word(listed_key(), 19'($urandom), 2'($urandom), 1'b1);
        if (sel < 90)
            return arinc_word(10'($urandom), 19'($urandom), 2'($urandom), 1'b1);
        return arinc_word(listed_key(), 19'($urandom), 2'($urandom), 1'b0);
    endfunction

    function automatic int next_gap();
        if (quick)
            return $urandom_range(0, 2);
        if (send_burst > 0)
        begin
            send_burst--;
            return 0;
        end
        if ($urandom_range(0, 9) == 0)
        begin
            send_burst = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, 19);
    endfunction

    function automatic void compare_field(input string name, input logic [31:0] got,
                                          input logic [31:0] want);
        if (got !== want)
        begin
            if (mismatches < 40)
                $display("%0d ns: %s mismatch, expected %0h, actual %0h",
                         $time, name, want, got);
            mismatches++;
        end
    endfunction

    task automatic push_item(input logic in_op, input logic [31:0] w, input int gap);
        word_item_t it;
        it.op = in_op;
        it.word = w;
        it.gap = gap;
        pending_words.push_back(it);
    endtask

    task automatic cfg_write(input logic [2:0] idx, input logic [31:0] val);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_STREAM_MODE:   cfg_now.stream_mode = val[0];
            REG_FILTER_ENABLE: cfg_now.filter_enable = val[0];
            REG_FILTER_0:      cfg_now.filter_entry_0 = val[9:0];
            REG_FILTER_1:      cfg_now.filter_entry_1 = val[9:0];
            REG_FILTER_2:      cfg_now.filter_entry_2 = val[9:0];
            REG_EXPECTED:      cfg_now.expected_words = val[10:0];
            REG_IDLE_FLUSH:    cfg_now.idle_flush_ticks = val[15:0];
            default: ;
        endcase
    endtask

    task automatic write_config(input logic stream, input logic filt, input logic [9:0] e0,
                                input logic [9:0] e1, input logic [9:0] e2,
                                input logic [10:0] expected, input logic [15:0] flush);
        cfg_write(REG_STREAM_MODE, 32'(stream));
        cfg_write(REG_FILTER_ENABLE, 32'(filt));
        cfg_write(REG_FILTER_0, 32'(e0));
        cfg_write(REG_FILTER_1, 32'(e1));
        cfg_write(REG_FILTER_2, 32'(e2));
        cfg_write(REG_EXPECTED, 32'(expected));
        cfg_write(REG_IDLE_FLUSH, 32'(flush));
        @(posedge clk);
    endtask

    // Hold until every queued transaction is sent and every result is back
    task automatic wait_drained();
        while (pending_words.size() != 0 || have_cur || in_valid
               || awaited_reports.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // A run of words followed by ticks, usually enough to close the batch
    task automatic push_batch();
        int n;
        int k;
        n = $urandom_range(1, 10);
        repeat (n) push_item(OP_WORD, pick_word(), next_gap());
        if (cfg_now.idle_flush_ticks > 16'd8)
            k = $urandom_range(0, 8);
        else if ($urandom_range(0, 3) == 0)
            k = $urandom_range(0, 32'(cfg_now.idle_flush_ticks));
        else
            k = int'(cfg_now.idle_flush_ticks) + int'($urandom_range(0, 2));
        repeat (k) push_item(OP_TICK, $urandom, next_gap());
        random_sent += n + k;
    endtask

    // Driver: advance on acceptance, otherwise hold the offered transaction
    always @(negedge clk)
    begin
        if (rst_n && !(in_valid && !in_taken))
        begin
            if (!have_cur && pending_words.size() != 0)
            begin
                cur_word = pending_words.pop_front();
                have_cur = 1'b1;
                gap_left = cur_word.gap;
            end
            if (have_cur && gap_left == 0)
            begin
                in_valid <= 1'b1;
                op <= cur_word.op;
                rx_word <= cur_word.word;
                have_cur = 1'b0;
            end
            else
            begin
                in_valid <= 1'b0;
                if (have_cur)
                    gap_left--;
            end
        end
    end

    always @(posedge clk)
    begin
        in_taken = rst_n && in_valid && !in_stall;
        if (in_taken)
            awaited_reports.push_back(filter_step(op, rx_word));
    end

    // Receiver: random stall per result, one long hold on request
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_off_req && !hold_served)
            begin
                hold_served = 1'b1;
                hold_left = 120;
            end
            if (out_taken)
            begin
                if (recv_burst > 0)
                begin
                    recv_burst--;
                    stall_left = 0;
                end
                else if ($urandom_range(0, 9) == 0)
                begin
                    recv_burst = $urandom_range(10, 40);
                    stall_left = 0;
                end
                else
                    stall_left = $urandom_range(0, 19);
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (out_valid && stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        filter_report_t want;
        out_taken = rst_n && out_valid && !out_stall;
        if (out_taken)
        begin
            if (awaited_reports.size() == 0)
            begin
                if (mismatches < 40)
                    $display("%0d ns: result with none expected, status %0h", $time, status);
                mismatches++;
            end
            else
            begin
                want = awaited_reports.pop_front();
                compare_field("status", 32'(status), 32'(want.status));
                compare_field("label", 32'(label), 32'(want.label));
                compare_field("sdi", 32'(sdi), 32'(want.sdi));
                compare_field("data", 32'(data), 32'(want.data));
                compare_field("ssm", 32'(ssm), 32'(want.ssm));
                compare_field("ack_tx", ack_tx, want.ack_tx);
                compare_field("batch_seq", batch_seq, want.batch_seq);
                compare_field("batch_words", 32'(batch_words), 32'(want.batch_words));
                compare_field("accepted_count", accepted_count, want.accepted_count);
                compare_field("filtered_count", filtered_count, want.filtered_count);
                compare_field("parity_error_count", parity_error_count,
                              want.parity_error_count);
                compare_field("overflow_count", overflow_count, want.overflow_count);
            end
        end
    end

    initial
    begin
        #10_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        int phase_no;
        int r;
        logic [10:0] exp_w;
        logic [15:0] flush;

        cfg_now.stream_mode = 1'b0;
        cfg_now.filter_enable = 1'b1;
        cfg_now.filter_entry_0 = RST_FILTER_0;
        cfg_now.filter_entry_1 = RST_FILTER_1;
        cfg_now.filter_entry_2 = RST_FILTER_2;
        cfg_now.expected_words = RST_EXPECTED;
        cfg_now.idle_flush_ticks = RST_IDLE_FLUSH;
        bat_fill = '0;
        bat_perr = '0;
        idle_run = '0;
        capture_open = 1'b0;
        closed_total = '0;
        acc_total = '0;
        filt_total = '0;
        par_total = '0;
        ovf_total = '0;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Defaults: tick with no batch, zero word, listed, unlisted and bad parity
        push_item(OP_TICK, 32'hFFFF_FFFF, next_gap());
        push_item(OP_WORD, 32'd0, next_gap());
        push_item(OP_WORD, arinc_word(10'h0A5, 19'd0, 2'd0, 1'b1), next_gap());
        push_item(OP_WORD, arinc_word(10'h1B1, 19'h7FFFF, 2'd3, 1'b1), next_gap());
        push_item(OP_WORD, arinc_word(10'h2C2, 19'($urandom), 2'($urandom), 1'b1),
                  next_gap());
        push_item(OP_WORD, arinc_word(10'h1A5, 19'($urandom), 2'($urandom), 1'b1),
                  next_gap());
        push_item(OP_WORD, arinc_word(10'h0A5, 19'($urandom), 2'($urandom), 1'b0),
                  next_gap());
        push_item(OP_WORD, 32'hFFFF_FFFF, next_gap());
        push_item(OP_WORD, 32'h7FFF_FFFF, next_gap());
        push_item(OP_WORD, 32'h8000_0000, next_gap());
        push_item(OP_TICK, 32'd0, next_gap());
        wait_drained();

        // Zero flush threshold closes on the first tick; dirty batch is incomplete
        cfg_write(REG_IDLE_FLUSH, 32'd0);
        @(posedge clk);
        push_item(OP_TICK, $urandom, next_gap());
        push_item(OP_TICK, $urandom, next_gap());
        wait_drained();

        // Clean complete batch; a zero word does not restart the idle count
        cfg_write(REG_EXPECTED, 32'd2);
        cfg_write(REG_IDLE_FLUSH, 32'd2);
        @(posedge clk);
        push_item(OP_WORD, arinc_word(10'h0A5, 19'($urandom), 2'($urandom), 1'b1),
                  next_gap());
        push_item(OP_WORD, arinc_word(10'h1B1, 19'($urandom), 2'($urandom), 1'b1),
                  next_gap());
        push_item(OP_TICK, $urandom, next_gap());
        push_item(OP_WORD, 32'd0, next_gap());
        push_item(OP_TICK, $urandom, next_gap());
        wait_drained();

        // Stream mode with filter off; unmapped register index is ignored
        cfg_write(3'd7, $urandom);
        cfg_write(REG_STREAM_MODE, 32'd1);
        cfg_write(REG_FILTER_ENABLE, 32'd0);
        @(posedge clk);
        push_item(OP_WORD, arinc_word(10'h3FF, 19'h7FFFF, 2'd3, 1'b1), next_gap());
        push_item(OP_WORD, arinc_word(10'h000, 19'd1, 2'd0, 1'b0), next_gap());
        push_item(OP_TICK, $urandom, next_gap());
        push_item(OP_WORD, 32'd0, next_gap());
        wait_drained();

        // Batch left open across stream mode stays frozen, then closes short
        cfg_write(REG_STREAM_MODE, 32'd0);
        cfg_write(REG_FILTER_ENABLE, 32'd1);
        @(posedge clk);
        push_item(OP_WORD, arinc_word(10'h2C2, 19'($urandom), 2'($urandom), 1'b1),
                  next_gap());
        wait_drained();
        cfg_write(REG_STREAM_MODE, 32'd1);
        @(posedge clk);
        push_item(OP_TICK, $urandom, next_gap());
        wait_drained();
        cfg_write(REG_STREAM_MODE, 32'd0);
        @(posedge clk);
        push_item(OP_TICK, $urandom, next_gap());
        push_item(OP_TICK, $urandom, next_gap());
        wait_drained();

        phase_no = 0;
        while (random_sent < 650)
        begin
            if (phase_no == 0)
                write_config(1'b0, 1'b1, 10'd0, 10'h3FF, 10'($urandom), 11'h7FF, 16'hFFFF);
            else if (phase_no == 1)
                write_config(1'b0, 1'b0, 10'h3FF, 10'd0, 10'($urandom), 11'd0, 16'd0);
            else
            begin
                r = $urandom_range(0, 9);
                exp_w = (r == 0) ? 11'd1024 : (r == 1) ? 11'($urandom_range(0, 2047))
                                                       : 11'($urandom_range(1, 8));
                flush = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 65535))
                                                    : 16'($urandom_range(1, 5));
                write_config($urandom_range(0, 4) == 0, $urandom_range(0, 3) != 0,
                             10'($urandom), 10'($urandom), 10'($urandom), exp_w, flush);
            end
            if (phase_no == 2)
            begin
                // Long receiver hold while the sender keeps offering
                hold_off_req = 1'b1;
                repeat (24) push_item(OP_WORD, pick_word(), 0);
                random_sent += 24;
            end
            repeat ($urandom_range(4, 10))
            begin
                if ($urandom_range(0, 4) == 0)
                begin
                    push_item(1'($urandom), $urandom, next_gap());
                    random_sent++;
                end
                else
                    push_batch();
            end
            wait_drained();
            phase_no++;
        end

        // Fill past capacity: overflow, then a full clean batch closes
        write_config(1'b0, 1'($urandom), 10'($urandom), 10'($urandom), 10'($urandom),
                     11'd1024, 16'd3);
        repeat (3) push_item(OP_TICK, $urandom, next_gap());
        quick = 1'b1;
        repeat (1030) push_item(OP_WORD, arinc_word(listed_key(), 19'($urandom),
                                                    2'($urandom), 1'b1), next_gap());
        repeat (3) push_item(OP_TICK, $urandom, next_gap());
        quick = 1'b0;
        wait_drained();

        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
